/* hw/rtl/desa_pkg.sv */
// ----------------------------------------------------------------------------
// desa_pkg
// Shared types and codes for the double-ended stack allocator.
// ----------------------------------------------------------------------------
package desa_pkg;

    localparam int DESA_ADDR_WIDTH = 32;
    localparam int FIELD_WIDTH     = 32;
    localparam int MAX_ALIGN_LOG2  = 16;

    // Command codes
    localparam logic [2:0] CMD_ALLOC_FRONT  = 3'd0;
    localparam logic [2:0] CMD_ALLOC_BACK   = 3'd1;
    localparam logic [2:0] CMD_RESET_TOPS   = 3'd2;
    localparam logic [2:0] CMD_REWIND_FRONT = 3'd3;
    localparam logic [2:0] CMD_REWIND_BACK  = 3'd4;
    localparam logic [2:0] CMD_READ_TOPS    = 3'd5;

    // Status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_EXHAUSTED  = 2'd1;
    localparam logic [1:0] STAT_BAD_MARKER = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] REG_REGION_START = 1'b0;
    localparam logic [0:0] REG_REGION_END   = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_F_ADD_OFF,
        OP_F_ROUND,
        OP_F_SUB_OFF,
        OP_F_ADD_SIZE,
        OP_B_SUB_SIZE,
        OP_B_ROUND,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_F4,
        ST_B1,
        ST_B2,
        ST_FINAL
    } ctl_state_t;

endpackage

/* hw/rtl/desa_ctrl.sv */
// ----------------------------------------------------------------------------
// desa_ctrl
// Sequencer: steps the datapath through each command and owns the
// handshakes of both channels.
// ----------------------------------------------------------------------------
module desa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_cmd,
    output logic             m_valid,
    input  logic             m_ready,
    output desa_pkg::dp_cmd_t dp_cmd
);
    import desa_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        dp_cmd.op      = OP_NONE;
        s_ready        = 1'b0;

        // drop the pending beat once taken
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dp_cmd.op = OP_LOAD;
                    if (s_cmd == CMD_ALLOC_FRONT) begin
                        state_next = ST_F1;
                    end else if (s_cmd == CMD_ALLOC_BACK) begin
                        state_next = ST_B1;
                    end else begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_F1: begin
                dp_cmd.op  = OP_F_ADD_OFF;
                state_next = ST_F2;
            end
            ST_F2: begin
                dp_cmd.op  = OP_F_ROUND;
                state_next = ST_F3;
            end
            ST_F3: begin
                dp_cmd.op  = OP_F_SUB_OFF;
                state_next = ST_F4;
            end
            ST_F4: begin
                dp_cmd.op  = OP_F_ADD_SIZE;
                state_next = ST_FINAL;
            end
            ST_B1: begin
                dp_cmd.op  = OP_B_SUB_SIZE;
                state_next = ST_B2;
            end
            ST_B2: begin
                dp_cmd.op  = OP_B_ROUND;
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                // hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    dp_cmd.op      = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

/* hw/rtl/desa_datapath.sv */
// ----------------------------------------------------------------------------
// desa_datapath
// Top pointers, region registers, work registers and result register.
// ----------------------------------------------------------------------------
module desa_datapath #(
    parameter int ADDR_WIDTH = desa_pkg::DESA_ADDR_WIDTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  desa_pkg::dp_cmd_t dp_cmd,
    input  logic [2:0]        s_cmd,
    input  logic [31:0]       s_alloc_size,
    input  logic [4:0]        s_align_log2,
    input  logic [15:0]       s_align_offset,
    input  logic [31:0]       s_rewind_point,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [31:0]       cfg_wdata,
    output logic [31:0]       m_block_address,
    output logic [1:0]        m_status,
    output logic [31:0]       m_front_marker,
    output logic [31:0]       m_back_marker
);
    import desa_pkg::*;

    localparam int AW = ADDR_WIDTH;

    logic [2:0]    cmd_reg, cmd_next;
    logic [AW-1:0] size_reg, size_next;
    logic [AW-1:0] amask_reg, amask_next;
    logic [AW-1:0] off_reg, off_next;
    logic [AW-1:0] point_reg, point_next;
    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] blk_reg, blk_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] front_top_reg, front_top_next;
    logic [AW-1:0] back_top_reg, back_top_next;
    logic [31:0]   region_start_reg, region_start_next;
    logic [31:0]   region_end_reg, region_end_next;
    logic [AW-1:0] block_reg, block_next;
    logic [1:0]    status_reg, status_next;

    // width adaption of the input fields
    logic [AW+31:0] size_wide, point_wide;
    logic [AW+15:0] off_wide;
    logic [4:0]     lg_clamped;
    logic [AW-1:0]  amask_in;

    // arithmetic
    logic [AW:0]    add_a, add_b, add_sum;
    logic [AW:0]    sub_a, sub_b, sub_diff;

    // region conversions and wide compares
    logic [AW+31:0] rs_wide, re_wide;
    logic [AW+31:0] pt_cmp, ft_cmp, bt_cmp;
    logic [AW+31:0] block_wide, ft_wide, bt_wide;

    assign size_wide  = {{AW{1'b0}}, s_alloc_size};
    assign point_wide = {{AW{1'b0}}, s_rewind_point};
    assign off_wide   = {{AW{1'b0}}, s_align_offset};

    always_comb begin
        if (s_align_log2 > 5'(MAX_ALIGN_LOG2)) begin
            lg_clamped = 5'(MAX_ALIGN_LOG2);
        end else begin
            lg_clamped = s_align_log2;
        end
        for (int i = 0; i < AW; i++) begin
            amask_in[i] = (i < int'(lg_clamped));
        end
    end

    assign rs_wide = {{AW{1'b0}}, region_start_reg};
    assign re_wide = {{AW{1'b0}}, region_end_reg};
    assign pt_cmp  = {32'd0, point_reg};
    assign ft_cmp  = {32'd0, front_top_reg};
    assign bt_cmp  = {32'd0, back_top_reg};

    // shared adder and subtractor, operands picked by step
    always_comb begin
        add_a = {1'b0, acc_reg};
        add_b = {1'b0, size_reg};
        sub_a = {1'b0, acc_reg};
        sub_b = {1'b0, off_reg};
        case (dp_cmd.op)
            OP_F_ADD_OFF: begin
                add_a = {1'b0, front_top_reg};
                add_b = {1'b0, off_reg};
            end
            OP_F_ROUND: begin
                add_b = {1'b0, amask_reg};
            end
            OP_B_SUB_SIZE: begin
                sub_a = {1'b0, back_top_reg};
                sub_b = {1'b0, size_reg};
            end
            OP_B_ROUND: begin
                sub_a = {1'b0, acc_reg & ~amask_reg};
            end
            default: begin
            end
        endcase
    end

    assign add_sum  = add_a + add_b;
    assign sub_diff = sub_a - sub_b;

    always_comb begin
        cmd_next          = cmd_reg;
        size_next         = size_reg;
        amask_next        = amask_reg;
        off_next          = off_reg;
        point_next        = point_reg;
        acc_next          = acc_reg;
        blk_next          = blk_reg;
        ovf_next          = ovf_reg;
        front_top_next    = front_top_reg;
        back_top_next     = back_top_reg;
        region_start_next = region_start_reg;
        region_end_next   = region_end_reg;
        block_next        = block_reg;
        status_next       = status_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                REG_REGION_START: region_start_next = cfg_wdata;
                REG_REGION_END:   region_end_next   = cfg_wdata;
                default: begin
                end
            endcase
        end

        case (dp_cmd.op)
            OP_LOAD: begin
                cmd_next   = s_cmd;
                size_next  = size_wide[AW-1:0];
                amask_next = amask_in;
                off_next   = off_wide[AW-1:0];
                point_next = point_wide[AW-1:0];
                ovf_next   = 1'b0;
            end
            OP_F_ADD_OFF: begin
                acc_next = add_sum[AW-1:0];
                ovf_next = ovf_reg | add_sum[AW];
            end
            OP_F_ROUND: begin
                acc_next = add_sum[AW-1:0] & ~amask_reg;
                ovf_next = ovf_reg | add_sum[AW];
            end
            OP_F_SUB_OFF: begin
                // wraps freely; only adds count as overflow here
                acc_next = sub_diff[AW-1:0];
                blk_next = sub_diff[AW-1:0];
            end
            OP_F_ADD_SIZE: begin
                acc_next = add_sum[AW-1:0];
                ovf_next = ovf_reg | add_sum[AW];
            end
            OP_B_SUB_SIZE: begin
                acc_next = sub_diff[AW-1:0];
                ovf_next = ovf_reg | sub_diff[AW];
            end
            OP_B_ROUND: begin
                acc_next = sub_diff[AW-1:0];
                ovf_next = ovf_reg | sub_diff[AW];
            end
            OP_FINISH: begin
                block_next  = '0;
                status_next = STAT_OK;
                case (cmd_reg)
                    CMD_ALLOC_FRONT: begin
                        if (ovf_reg || !(acc_reg < back_top_reg)) begin
                            status_next = STAT_EXHAUSTED;
                        end else begin
                            front_top_next = acc_reg;
                            block_next     = blk_reg;
                        end
                    end
                    CMD_ALLOC_BACK: begin
                        if (ovf_reg || !(acc_reg > front_top_reg)) begin
                            status_next = STAT_EXHAUSTED;
                        end else begin
                            back_top_next = acc_reg;
                            block_next    = acc_reg;
                        end
                    end
                    CMD_RESET_TOPS: begin
                        front_top_next = rs_wide[AW-1:0];
                        back_top_next  = re_wide[AW-1:0];
                    end
                    CMD_REWIND_FRONT: begin
                        if (pt_cmp >= rs_wide && pt_cmp <= ft_cmp) begin
                            front_top_next = point_reg;
                        end else begin
                            status_next = STAT_BAD_MARKER;
                        end
                    end
                    CMD_REWIND_BACK: begin
                        if (pt_cmp >= bt_cmp && pt_cmp <= re_wide) begin
                            back_top_next = point_reg;
                        end else begin
                            status_next = STAT_BAD_MARKER;
                        end
                    end
                    default: begin
                        // read tops and unused codes report only
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_top_reg    <= '0;
            back_top_reg     <= '0;
            region_start_reg <= '0;
            region_end_reg   <= '0;
            ovf_reg          <= 1'b0;
            cmd_reg          <= CMD_READ_TOPS;
        end else begin
            front_top_reg    <= front_top_next;
            back_top_reg     <= back_top_next;
            region_start_reg <= region_start_next;
            region_end_reg   <= region_end_next;
            ovf_reg          <= ovf_next;
            cmd_reg          <= cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg   <= size_next;
        amask_reg  <= amask_next;
        off_reg    <= off_next;
        point_reg  <= point_next;
        acc_reg    <= acc_next;
        blk_reg    <= blk_next;
        block_reg  <= block_next;
        status_reg <= status_next;
    end

    // tops only move on a finish step, which waits for the result beat to clear
    assign block_wide = {32'd0, block_reg};
    assign ft_wide    = {32'd0, front_top_reg};
    assign bt_wide    = {32'd0, back_top_reg};

    assign m_block_address = block_wide[31:0];
    assign m_status        = status_reg;
    assign m_front_marker  = ft_wide[31:0];
    assign m_back_marker   = bt_wide[31:0];

endmodule

/* hw/rtl/double_ended_stack_allocator.sv */
// ----------------------------------------------------------------------------
// double_ended_stack_allocator
// Carves blocks off both ends of one address region, with rewind and reset.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    cmd, alloc_size, align_log2,
//                                         align_offset, rewind_point
//  m_       out        m_valid/m_ready    block_address, status,
//                                         front_marker, back_marker
//  cfg_     in         cfg_we             cfg_index, cfg_wdata
//
//  A front allocation steps through add offset, round, subtract offset and
//  add size, a back allocation through subtract size and round, any other
//  command to the final step; shared adder and subtractor, one step per cycle.
//  A result beat waits in the output register while the next command is taken
//  and computed; the final step of that command holds until the beat is gone.
//  Reset clears both tops and both region registers to zero.
// ----------------------------------------------------------------------------
module double_ended_stack_allocator #(
    parameter int ADDR_WIDTH = desa_pkg::DESA_ADDR_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [31:0] s_alloc_size,
    input  logic [4:0]  s_align_log2,
    input  logic [15:0] s_align_offset,
    input  logic [31:0] s_rewind_point,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_block_address,
    output logic [1:0]  m_status,
    output logic [31:0] m_front_marker,
    output logic [31:0] m_back_marker,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import desa_pkg::*;

    dp_cmd_t dp_cmd;

    desa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd)
    );

    desa_datapath #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .dp_cmd          (dp_cmd),
        .s_cmd           (s_cmd),
        .s_alloc_size    (s_alloc_size),
        .s_align_log2    (s_align_log2),
        .s_align_offset  (s_align_offset),
        .s_rewind_point  (s_rewind_point),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .m_block_address (m_block_address),
        .m_status        (m_status),
        .m_front_marker  (m_front_marker),
        .m_back_marker   (m_back_marker)
    );

endmodule
